// ===== design/hrep_pkg.sv =====
// Package: payload types, state enum and sizing constants for the ramp event player
`default_nettype none
package hrep_pkg;

   localparam int QueueDepthDefault = 8;
   localparam int LevelW = 16;
   localparam int DurW = 24;
   localparam int TimeW = 32;

   localparam logic ReqQueue = 1'b0;
   localparam logic ReqTick  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] start_level;
      logic [15:0] end_level;
      logic [23:0] duration_us;
      logic [31:0] now_us;
   } req_type_type;

   typedef struct packed {
      logic        pulse_fire;
      logic [15:0] pulse_level;
      logic [3:0]  events_left;
   } rsp_type_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DIV,
      ST_SCAN,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== design/haptic_ramp_event_player.sv =====
// Top level: haptic ramp event queue with serial divider and serial compaction
//
//  channel | dir | ports
//  req     | in  | req_valid, req_ready, req_data
//  rsp     | out | rsp_valid, rsp_ready, rsp_data
//
// A queue item is written straight into the queue, or, when the queue is full,
// goes through a serial shift that drops the oldest entry. A tick on an empty
// queue goes straight to the result. Any other tick runs the 40-bit
// restoring divider (one quotient bit per cycle), then one compaction step per
// queued entry (at most QUEUE_DEPTH), then the result. Reset empties the queue.
// The block takes no item while one is in work or while a result waits on rsp_ready.
`default_nettype none
module haptic_ramp_event_player
   import hrep_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type_type      rsp_data
);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [LevelW-1:0] st_start_ff [QUEUE_DEPTH];
   logic [LevelW-1:0] st_end_ff   [QUEUE_DEPTH];
   logic [DurW-1:0]   st_len_ff   [QUEUE_DEPTH];
   logic [TimeW-1:0]  st_began_ff [QUEUE_DEPTH];
   logic              st_fresh_ff [QUEUE_DEPTH];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] rd_ff;     // scan/shift read index
   logic [CW-1:0] kept_ff;
   logic [5:0]    bit_ff;
   req_type_type  item_ff;
   logic [39:0]   num_ff;    // dividend/quotient shift register
   logic [23:0]   rem_ff;
   logic          up_ff;
   logic [LevelW-1:0] base_ff;
   logic [LevelW-1:0] level_ff;
   logic          zdur_ff;

   logic [IW-1:0] last_idx, rd_idx, kept_idx;
   assign last_idx = IW'(count_ff - CW'(1));
   assign rd_idx   = rd_ff[IW-1:0];
   assign kept_idx = kept_ff[IW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == ReqQueue) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) state_in = ST_SHIFT;
               end else if (count_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_SHIFT: if (rd_ff == CW'(QUEUE_DEPTH - 1)) state_in = ST_IDLE;
         ST_DIV:   if (bit_ff == 6'd0) state_in = ST_SCAN;
         ST_SCAN:  if (rd_ff == count_ff - CW'(1)) state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      rsp_data.pulse_fire  = (level_ff != '0);
      rsp_data.pulse_level = level_ff;
      rsp_data.events_left = 4'(count_ff);
   end

   // elapsed time of the newest entry, clipped to its duration
   logic [TimeW-1:0] lat_began;
   logic [TimeW-1:0] elapsed;
   logic [DurW-1:0]  clip;
   logic [LevelW-1:0] diff;
   always_comb begin
      lat_began = st_fresh_ff[last_idx] ? req_data.now_us : st_began_ff[last_idx];
      elapsed   = req_data.now_us - lat_began;
      clip      = (elapsed > TimeW'(st_len_ff[last_idx])) ? st_len_ff[last_idx]
                                                           : elapsed[DurW-1:0];
      diff      = (st_end_ff[last_idx] >= st_start_ff[last_idx])
                  ? st_end_ff[last_idx] - st_start_ff[last_idx]
                  : st_start_ff[last_idx] - st_end_ff[last_idx];
   end

   logic [24:0] trial;
   logic [DurW-1:0] dur_last;
   assign dur_last = st_len_ff[last_idx];
   assign trial = {rem_ff, num_ff[39]} - {1'b0, dur_last};

   logic [TimeW-1:0] el_scan;
   assign el_scan = item_ff.now_us - st_began_ff[rd_idx];
   logic live;
   assign live = el_scan < TimeW'(st_len_ff[rd_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  kept_ff <= '0;
                  if (req_data.req_type == ReqQueue) begin
                     rd_ff <= CW'(1);
                     if (count_ff != CW'(QUEUE_DEPTH)) begin
                        st_start_ff[count_ff[IW-1:0]] <= req_data.start_level;
                        st_end_ff[count_ff[IW-1:0]]   <= req_data.end_level;
                        st_len_ff[count_ff[IW-1:0]]   <= req_data.duration_us;
                        st_began_ff[count_ff[IW-1:0]] <= '0;
                        st_fresh_ff[count_ff[IW-1:0]] <= 1'b1;
                        count_ff <= count_ff + CW'(1);
                     end
                  end else if (count_ff == '0) begin
                     level_ff <= '0;
                  end else begin
                     st_fresh_ff[last_idx] <= 1'b0;
                     st_began_ff[last_idx] <= lat_began;
                     num_ff  <= 40'(diff) * 40'(clip);
                     rem_ff  <= '0;
                     bit_ff  <= 6'd39;
                     up_ff   <= (st_end_ff[last_idx] >= st_start_ff[last_idx]);
                     base_ff <= st_start_ff[last_idx];
                     zdur_ff <= (dur_last == '0);
                     rd_ff   <= '0;
                  end
               end
            end
            ST_SHIFT: begin
               // move entry rd down one place, then append the new item on top
               st_start_ff[IW'(rd_ff - CW'(1))] <= st_start_ff[rd_idx];
               st_end_ff[IW'(rd_ff - CW'(1))]   <= st_end_ff[rd_idx];
               st_len_ff[IW'(rd_ff - CW'(1))]   <= st_len_ff[rd_idx];
               st_began_ff[IW'(rd_ff - CW'(1))] <= st_began_ff[rd_idx];
               st_fresh_ff[IW'(rd_ff - CW'(1))] <= st_fresh_ff[rd_idx];
               rd_ff <= rd_ff + CW'(1);
               if (rd_ff == CW'(QUEUE_DEPTH - 1)) begin
                  st_start_ff[IW'(QUEUE_DEPTH - 1)] <= item_ff.start_level;
                  st_end_ff[IW'(QUEUE_DEPTH - 1)]   <= item_ff.end_level;
                  st_len_ff[IW'(QUEUE_DEPTH - 1)]   <= item_ff.duration_us;
                  st_began_ff[IW'(QUEUE_DEPTH - 1)] <= '0;
                  st_fresh_ff[IW'(QUEUE_DEPTH - 1)] <= 1'b1;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit per cycle
               if (!trial[24]) begin
                  rem_ff <= trial[23:0];
                  num_ff <= {num_ff[38:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[22:0], num_ff[39]};
                  num_ff <= {num_ff[38:0], 1'b0};
               end
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd0) begin
                  if (zdur_ff) level_ff <= base_ff;
                  else if (up_ff)
                     level_ff <= base_ff + (!trial[24] ? LevelW'({num_ff[14:0], 1'b1})
                                                       : LevelW'({num_ff[14:0], 1'b0}));
                  else
                     level_ff <= base_ff - (!trial[24] ? LevelW'({num_ff[14:0], 1'b1})
                                                       : LevelW'({num_ff[14:0], 1'b0}));
               end
            end
            ST_SCAN: begin
               // keep live entries in order
               if (live) begin
                  st_start_ff[kept_idx] <= st_start_ff[rd_idx];
                  st_end_ff[kept_idx]   <= st_end_ff[rd_idx];
                  st_len_ff[kept_idx]   <= st_len_ff[rd_idx];
                  st_began_ff[kept_idx] <= st_began_ff[rd_idx];
                  st_fresh_ff[kept_idx] <= st_fresh_ff[rd_idx];
               end
               rd_ff <= rd_ff + CW'(1);
               if (rd_ff == count_ff - CW'(1))
                  count_ff <= kept_ff + CW'(live);
               else
                  kept_ff <= kept_ff + CW'(live);
            end
            ST_OUT: ;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire
